// ===== rtl/twcm_pkg.sv =====
// Shared types, constants and helper functions of the time weighted circular mean block.
package twcm_pkg;

    // CORDIC datapath: x and y words, angle accumulator in 2^-24 turn
    localparam int CW        = 48;
    localparam int ZW        = 26;
    localparam int STEPS     = 16;
    localparam int STEP_W    = 4;
    localparam int LUT_W     = 22;
    localparam int ACC_W     = 45;
    localparam int WIN_W     = 20;
    localparam int TIME_W    = 48;
    localparam int ANGLE_W   = 16;
    localparam int PROD_W    = 37;

    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 48'sd652032874;
    localparam logic signed [ZW-1:0] HALF_TURN       = 26'sd8388608;

    // Configuration register indexes
    localparam logic REG_WINDOW       = 1'b0;
    localparam logic REG_MIN_INTERVAL = 1'b1;

    typedef logic signed [CW-1:0] t_cword;
    typedef logic signed [ZW-1:0] t_zword;

    // arctan(2^-i) in units of 2^-24 turn
    function automatic logic [LUT_W-1:0] atan_lut(input logic [STEP_W-1:0] step);
        logic [LUT_W-1:0] v;
        case (step)
            4'd0:    v = 22'd2097152;
            4'd1:    v = 22'd1238021;
            4'd2:    v = 22'd654136;
            4'd3:    v = 22'd332050;
            4'd4:    v = 22'd166669;
            4'd5:    v = 22'd83416;
            4'd6:    v = 22'd41718;
            4'd7:    v = 22'd20860;
            4'd8:    v = 22'd10430;
            4'd9:    v = 22'd5215;
            4'd10:   v = 22'd2608;
            4'd11:   v = 22'd1304;
            4'd12:   v = 22'd652;
            4'd13:   v = 22'd326;
            4'd14:   v = 22'd163;
            4'd15:   v = 22'd81;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // Round a Q2.30 value to Q1.15 and clamp to the symmetric range.
    function automatic logic signed [15:0] q30_to_q15(input t_cword v);
        t_cword r;
        r = v + 48'sd16384;
        r = r >>> 15;
        if (r > 48'sd32767) begin
            return 16'sd32767;
        end else if (r < -48'sd32767) begin
            return -16'sd32767;
        end else begin
            return r[15:0];
        end
    endfunction

endpackage

// ===== rtl/twcm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module twcm_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/twcm_cordic.sv =====
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
module twcm_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_vector,
    input  twcm_pkg::t_cword   i_x,
    input  twcm_pkg::t_cword   i_y,
    input  twcm_pkg::t_zword   i_z,
    output logic               o_done,
    output twcm_pkg::t_cword   o_x,
    output twcm_pkg::t_cword   o_y,
    output twcm_pkg::t_zword   o_z
);
    twcm_pkg::t_cword r_x, r_y, n_x, n_y;
    twcm_pkg::t_zword r_z, n_z;
    logic [twcm_pkg::STEP_W-1:0] r_step;
    logic r_vec, r_busy, r_done;

    twcm_pkg::t_cword dx, dy;
    twcm_pkg::t_zword ang;
    logic pos;

    always_comb begin
        dx  = r_y >>> r_step;
        dy  = r_x >>> r_step;
        ang = $signed({{(twcm_pkg::ZW - twcm_pkg::LUT_W){1'b0}}, twcm_pkg::atan_lut(r_step)});
        // Rotation drives z to zero, vectoring drives y to zero.
        pos = r_vec ? r_y[twcm_pkg::CW-1] : ~r_z[twcm_pkg::ZW-1];
        if (pos) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - ang;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == twcm_pkg::STEP_W'(twcm_pkg::STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_vec <= i_vector;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule

// ===== rtl/time_weighted_circular_mean.sv =====
// Top level of the time weighted circular mean of rotary angle samples.
//
//  channel   direction  handshake            payload (lowest bit first)
//  s_*       in         s_tvalid / s_tready  s_tdata: angle[15:0], time_us[63:16]
//  m_*       out        m_tvalid / m_tready  m_tdata: smoothed_angle; m_tuser: updated
//  i_cfg_*   in         i_cfg_we             i_cfg_idx selects, i_cfg_data is the value
//
// A request whose timestamp is less than the minimum interval after the newest
// stored sample is answered in the cycle after acceptance with the held angle.
// A fresh request goes from acceptance to the result through the 16-step
// sine/cosine CORDIC, then the read, weight, sine product, cosine product and
// accumulate phases of each history entry through the single shared multiplier,
// a set-up state, the normalisation shifter and the 16-step vectoring CORDIC.
// Reset is synchronous; it clears all valid bits of the history so no clearing
// pass is needed. s_tready is low while a request is in work and while a result
// waits in the output register; m_tready low only stalls that register.
module time_weighted_circular_mean #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // angle[15:0], time_us[63:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // smoothed_angle[15:0]
    output logic [0:0]  m_tuser,   // updated[0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [19:0] i_cfg_data
);
    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int MEM_W = twcm_pkg::TIME_W + 32;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SINCOS = 3'd1;
    localparam logic [2:0] ST_ACC    = 3'd2;
    localparam logic [2:0] ST_PREP   = 3'd3;
    localparam logic [2:0] ST_NORM   = 3'd4;
    localparam logic [2:0] ST_VEC    = 3'd5;

    localparam logic [2:0] PH_READ = 3'd0;
    localparam logic [2:0] PH_WGT  = 3'd1;
    localparam logic [2:0] PH_MSIN = 3'd2;
    localparam logic [2:0] PH_MCOS = 3'd3;
    localparam logic [2:0] PH_ACC  = 3'd4;

    localparam twcm_pkg::t_cword LIM36 = 48'sd68719476736;
    localparam twcm_pkg::t_cword LIM40 = 48'sd1099511627776;

    logic [2:0] r_state, r_ph;
    logic [AW-1:0] r_wslot, r_k, next_slot;
    logic [HISTORY_DEPTH-1:0] r_valid;
    logic [twcm_pkg::TIME_W-1:0] r_last, r_now;
    logic [twcm_pkg::ANGLE_W-1:0] r_angle, r_held;
    logic [twcm_pkg::WIN_W-1:0] r_window, r_min_int;
    logic [twcm_pkg::WIN_W-1:0] r_w, n_w;
    logic signed [15:0] r_sin, r_cos;
    logic signed [twcm_pkg::PROD_W-1:0] r_prod;
    logic signed [twcm_pkg::ACC_W-1:0] r_acc_s, r_acc_c;
    twcm_pkg::t_cword r_nx, r_ny;
    twcm_pkg::t_zword r_nz, z_round;
    logic r_out_valid, r_out_upd;
    logic [15:0] r_out_angle;

    logic accept, fresh;
    logic signed [twcm_pkg::TIME_W:0] gap;
    logic cor_start, cor_vec, cor_done;
    twcm_pkg::t_cword cor_x, cor_y, cor_ox, cor_oy, xs0, ys0;
    twcm_pkg::t_zword cor_z, cor_oz;
    logic signed [15:0] q_c, q_s, sc_sin, sc_cos;
    logic ram_we, ram_re;
    logic [MEM_W-1:0] ram_wdata, ram_rdata;
    logic [twcm_pkg::TIME_W-1:0] ent_time, age;
    logic signed [15:0] mul_op;
    logic small36, small40;

    assign s_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign accept   = s_tvalid && s_tready;
    assign gap      = $signed({1'b0, s_tdata[63:16]}) - $signed({1'b0, r_last});
    assign fresh    = gap >= $signed({{(twcm_pkg::TIME_W + 1 - twcm_pkg::WIN_W){1'b0}}, r_min_int});
    assign next_slot = (r_wslot == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wslot + 1'b1;

    // Sine/cosine CORDIC on the angle within its quadrant, then vectoring for atan2.
    assign cor_start = (accept && fresh) || ((r_state == ST_NORM) && !small40);
    assign cor_vec   = (r_state != ST_IDLE);
    assign cor_x     = cor_vec ? r_nx : twcm_pkg::CORDIC_GAIN_Q30;
    assign cor_y     = cor_vec ? r_ny : '0;
    assign cor_z     = cor_vec ? r_nz : $signed({4'b0, s_tdata[13:0], 8'b0});

    twcm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_vector(cor_vec),
        .i_x     (cor_x),
        .i_y     (cor_y),
        .i_z     (cor_z),
        .o_done  (cor_done),
        .o_x     (cor_ox),
        .o_y     (cor_oy),
        .o_z     (cor_oz)
    );

    // Move the first-quadrant result to the quadrant of the angle.
    always_comb begin
        q_c = twcm_pkg::q30_to_q15(cor_ox);
        q_s = twcm_pkg::q30_to_q15(cor_oy);
        case (r_angle[15:14])
            2'd0: begin
                sc_sin = q_s;
                sc_cos = q_c;
            end
            2'd1: begin
                sc_sin = q_c;
                sc_cos = -q_s;
            end
            2'd2: begin
                sc_sin = -q_s;
                sc_cos = -q_c;
            end
            default: begin
                sc_sin = -q_c;
                sc_cos = q_s;
            end
        endcase
    end

    // History ring: time, sine and cosine of each stored sample.
    assign ram_we    = (r_state == ST_SINCOS) && cor_done;
    assign ram_wdata = {r_now, sc_sin, sc_cos};
    assign ram_re    = (r_state == ST_ACC) && (r_ph == PH_READ);

    twcm_ram #(
        .WIDTH(MEM_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wslot),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_k),
        .o_rdata(ram_rdata)
    );

    // Weight of an entry: window minus age, a future timestamp counting as age zero.
    always_comb begin
        ent_time = ram_rdata[MEM_W-1:32];
        age      = r_now - ent_time;
        if (!r_valid[r_k]) begin
            n_w = '0;
        end else if (ent_time > r_now) begin
            n_w = r_window;
        end else if (age < {{(twcm_pkg::TIME_W - twcm_pkg::WIN_W){1'b0}}, r_window}) begin
            n_w = r_window - age[twcm_pkg::WIN_W-1:0];
        end else begin
            n_w = '0;
        end
    end

    assign mul_op = (r_ph == PH_MSIN) ? r_sin : r_cos;

    // atan2 set-up: zero cosine sum becomes one LSB, negative cosine turns half a turn.
    always_comb begin
        xs0 = (r_acc_c == '0) ? 48'sd1 : twcm_pkg::CW'(r_acc_c);
        ys0 = twcm_pkg::CW'(r_acc_s);
    end

    assign small36 = (r_nx < LIM36) && (r_ny < LIM36) && (r_ny > -LIM36);
    assign small40 = (r_nx < LIM40) && (r_ny < LIM40) && (r_ny > -LIM40);
    assign z_round = cor_oz + 26'sd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ph        <= PH_READ;
            r_k         <= '0;
            r_wslot     <= '0;
            r_valid     <= '0;
            r_last      <= '0;
            r_held      <= '0;
            r_window    <= 20'd48000;
            r_min_int   <= 20'd900;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    twcm_pkg::REG_WINDOW:       r_window  <= i_cfg_data;
                    twcm_pkg::REG_MIN_INTERVAL: r_min_int <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (fresh) begin
                            r_wslot <= next_slot;
                            r_last  <= s_tdata[63:16];
                            r_state <= ST_SINCOS;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_angle <= r_held;
                            r_out_upd   <= 1'b0;
                        end
                    end
                end
                ST_SINCOS: begin
                    if (cor_done) begin
                        r_valid[r_wslot] <= 1'b1;
                        r_k     <= '0;
                        r_ph    <= PH_READ;
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    case (r_ph)
                        PH_READ: r_ph <= PH_WGT;
                        PH_WGT:  r_ph <= PH_MSIN;
                        PH_MSIN: r_ph <= PH_MCOS;
                        PH_MCOS: r_ph <= PH_ACC;
                        default: begin
                            r_ph <= PH_READ;
                            r_k  <= r_k + 1'b1;
                            if (r_k == AW'(HISTORY_DEPTH - 1)) begin
                                r_state <= ST_PREP;
                            end
                        end
                    endcase
                end
                ST_PREP: r_state <= ST_NORM;
                ST_NORM: begin
                    if (!small40) begin
                        r_state <= ST_VEC;
                    end
                end
                ST_VEC: begin
                    if (cor_done) begin
                        r_held      <= z_round[23:8];
                        r_out_valid <= 1'b1;
                        r_out_angle <= z_round[23:8];
                        r_out_upd   <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_angle <= s_tdata[15:0];
            r_now   <= s_tdata[63:16];
        end
        if ((r_state == ST_SINCOS) && cor_done) begin
            r_acc_s <= '0;
            r_acc_c <= '0;
        end
        if (r_state == ST_ACC) begin
            case (r_ph)
                PH_WGT: begin
                    r_w   <= n_w;
                    r_sin <= $signed(ram_rdata[31:16]);
                    r_cos <= $signed(ram_rdata[15:0]);
                end
                PH_MSIN: r_prod <= $signed({1'b0, r_w}) * mul_op;
                PH_MCOS: begin
                    r_acc_s <= r_acc_s + twcm_pkg::ACC_W'(r_prod);
                    r_prod  <= $signed({1'b0, r_w}) * mul_op;
                end
                PH_ACC: r_acc_c <= r_acc_c + twcm_pkg::ACC_W'(r_prod);
                default: ;
            endcase
        end
        if (r_state == ST_PREP) begin
            if (xs0[twcm_pkg::CW-1]) begin
                r_nx <= -xs0;
                r_ny <= -ys0;
                r_nz <= twcm_pkg::HALF_TURN;
            end else begin
                r_nx <= xs0;
                r_ny <= ys0;
                r_nz <= '0;
            end
        end else if (r_state == ST_NORM) begin
            // Four doublings at once while both stay well clear of the limit.
            if (small36) begin
                r_nx <= r_nx <<< 4;
                r_ny <= r_ny <<< 4;
            end else if (small40) begin
                r_nx <= r_nx <<< 1;
                r_ny <= r_ny <<< 1;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_angle;
    assign m_tuser  = r_out_upd;
endmodule

// ===== rtl/twcm_chk.sv =====
// Port-level checker for the time weighted circular mean block, bound to the top level.
module twcm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The block never takes a request while a result is still waiting.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !m_tvalid)
        else $error("request accepted with result pending");

    // After a request is taken the block is busy in the following cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready did not drop after a request");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind time_weighted_circular_mean twcm_chk u_twcm_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// ===== dv/time_weighted_circular_mean_tb.sv =====
// Self-checking testbench of the time weighted circular mean block.
module time_weighted_circular_mean_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    // Arctangent table in units of 2^-24 turn, the same values the block rotates by.
    localparam longint ATAN_STEP [16] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic [15:0] smoothed_angle;
        logic        updated;
    } t_smoothed;

    // Holds its own copy of the history ring and registers, and the queue of
    // answers that the block still owes.
    class mean_scoreboard;
        longint      ring_time [DEPTH];
        longint      ring_sine [DEPTH];
        longint      ring_cosine [DEPTH];
        int          newest;
        logic [15:0] held_angle;
        longint      window_us;
        longint      min_interval_us;
        t_smoothed   owed_q[$];
        int          errors;
        int          fresh_count;
        int          held_count;

        function new();
            for (int k = 0; k < DEPTH; k++) begin
                ring_time[k] = 0;
                ring_sine[k] = 0;
                ring_cosine[k] = 0;
            end
            newest = 0;
            held_angle = '0;
            window_us = 48000;
            min_interval_us = 900;
            errors = 0;
            fresh_count = 0;
            held_count = 0;
        endfunction

        function void write_reg(logic idx, logic [19:0] value);
            if (idx == twcm_pkg::REG_WINDOW) begin
                window_us = value;
            end else begin
                min_interval_us = value;
            end
        endfunction

        static function longint to_q15(longint v);
            longint r;
            r = (v + (64'sd1 <<< 14)) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32767) r = -32767;
            return r;
        endfunction

        static function void rotate(logic [15:0] angle, output longint s, output longint c);
            longint x, y, z, dx, dy, qs, qc;
            x = 652032874;
            y = 0;
            z = longint'(angle[13:0]) * 256;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= ATAN_STEP[i];
                end else begin
                    x += dx; y -= dy; z += ATAN_STEP[i];
                end
            end
            qc = to_q15(x);
            qs = to_q15(y);
            case (angle[15:14])
                2'd0: begin s = qs;  c = qc;  end
                2'd1: begin s = qc;  c = -qs; end
                2'd2: begin s = -qs; c = -qc; end
                default: begin s = -qc; c = qs; end
            endcase
        endfunction

        static function logic [15:0] bearing(longint ys, longint xs);
            longint z, dx, dy;
            z = 0;
            if (xs < 0) begin
                xs = -xs; ys = -ys; z = 64'sd1 <<< 23;
            end
            while (xs < (64'sd1 <<< 40) && ys < (64'sd1 <<< 40) && ys > -(64'sd1 <<< 40)) begin
                xs *= 2;
                ys *= 2;
            end
            for (int i = 0; i < 16; i++) begin
                dx = ys >>> i;
                dy = xs >>> i;
                if (ys >= 0) begin
                    xs += dx; ys -= dy; z += ATAN_STEP[i];
                end else begin
                    xs -= dx; ys += dy; z -= ATAN_STEP[i];
                end
            end
            z = (z + 128) >>> 8;
            return z[15:0];
        endfunction

        // Works out the answer owed for one accepted request.
        function void note_request(logic [15:0] angle, logic [47:0] stamp);
            longint now, age, w, sines, cosines;
            t_smoothed r;
            now = longint'(stamp);
            if (now - ring_time[newest] < min_interval_us) begin
                r.smoothed_angle = held_angle;
                r.updated = 1'b0;
                held_count++;
            end else begin
                newest = (newest + 1) % DEPTH;
                ring_time[newest] = now;
                rotate(angle, ring_sine[newest], ring_cosine[newest]);
                sines = 0;
                cosines = 0;
                for (int k = 0; k < DEPTH; k++) begin
                    age = now - ring_time[k];
                    if (age < 0) age = 0;
                    w = window_us - age;
                    if (w > 0) begin
                        sines += w * ring_sine[k];
                        cosines += w * ring_cosine[k];
                    end
                end
                if (cosines == 0) cosines = 1;
                held_angle = bearing(sines, cosines);
                r.smoothed_angle = held_angle;
                r.updated = 1'b1;
                fresh_count++;
            end
            owed_q.push_back(r);
        endfunction

        function void check_result(logic [15:0] angle, logic updated);
            t_smoothed e;
            if (owed_q.size() == 0) begin
                $error("result %0h/%0b arrived with nothing owed", angle, updated);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (angle !== e.smoothed_angle) begin
                $error("smoothed_angle expected %0d got %0d", e.smoothed_angle, angle);
                errors++;
            end
            if (updated !== e.updated) begin
                $error("updated expected %0b got %0b", e.updated, updated);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // angle[15:0], time_us[63:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // smoothed_angle[15:0]
    logic [0:0]  m_tuser;   // updated[0]
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [19:0] i_cfg_data;

    mean_scoreboard board;
    longint  clock_us;      // running timestamp used for well-formed sequences
    int      idle_pct;      // chance in a hundred that a side idles this cycle
    int      quiet_cycles;
    bit      stim_done;

    time_weighted_circular_mean #(.HISTORY_DEPTH(DEPTH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        board = new();
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = twcm_pkg::REG_WINDOW;
        i_cfg_data = '0;
        idle_pct = 37;
        quiet_cycles = 0;
        stim_done = 1'b0;
        clock_us = 0;
    end

    // The receiver stalls at random; results are checked at the edge that takes them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata, m_tuser[0]);
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (i_rst_n && !(stim_done && board.owed_q.size() == 0)) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results owed", board.owed_q.size());
                $display("FAIL time_weighted_circular_mean");
                $finish;
            end
        end
    end

    // Offers one request, with a random gap in front of it, and holds it until taken.
    // Valid is left high at the accepting edge; the next call or drain drops it.
    task automatic send_request(logic [15:0] angle, logic [47:0] stamp);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {stamp, angle};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        board.note_request(angle, stamp);
    endtask

    // Waits until every owed result has come, then lets the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.owed_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        board.write_reg(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Next timestamp: mostly a forward step near the spacing, sometimes close,
    // backwards or a large jump, so both held and fresh answers keep coming.
    task automatic next_stamp(output logic [47:0] stamp);
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            clock_us += board.min_interval_us + $urandom_range(3000);
        end else if (pick < 82) begin
            clock_us += $urandom_range(32'(board.min_interval_us));
        end else if (pick < 90) begin
            clock_us -= $urandom_range(5000);
            if (clock_us < 0) clock_us = 0;
        end else if (pick < 96) begin
            clock_us += board.window_us + $urandom_range(100000);
        end else begin
            clock_us = {$urandom(), $urandom()} & 48'hFFFF_FFFF_FFFF;
        end
        stamp = clock_us[47:0];
    endtask

    task automatic random_phase(int count, int window_val, int interval_val);
        logic [47:0] stamp;
        logic [15:0] base;
        drain();
        write_reg(twcm_pkg::REG_WINDOW, 20'(window_val));
        write_reg(twcm_pkg::REG_MIN_INTERVAL, 20'(interval_val));
        base = 16'($urandom());
        for (int n = 0; n < count; n++) begin
            next_stamp(stamp);
            // a slowly turning shaft with jitter, now and then a wild angle
            if ($urandom_range(9) == 0) begin
                base = 16'($urandom());
            end else begin
                base = base + 16'(int'($urandom_range(2000)) - 1000);
            end
            send_request(base, stamp);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: before any sample the newest time is zero, so small stamps are held.
        send_request(16'h1234, 48'd0);
        send_request(16'h0000, 48'd900);
        send_request(16'hFFFF, 48'd1800);
        send_request(16'h4000, 48'd2700);
        send_request(16'h8000, 48'd3600);
        send_request(16'hC000, 48'd4500);
        send_request(16'h3FFF, 48'd5400);
        send_request(16'h7FFF, 48'd6300);
        // time running backwards and a too close sample are both held
        send_request(16'h5555, 48'd100);
        send_request(16'hAAAA, 48'd6301);
        // opposite angles cancel, leaving a zero cosine sum
        drain();
        write_reg(twcm_pkg::REG_WINDOW, 20'd1);
        write_reg(twcm_pkg::REG_MIN_INTERVAL, 20'd0);
        send_request(16'h4000, 48'd10000);
        send_request(16'hC000, 48'd10000);
        send_request(16'h8000, 48'd10000);
        // window of zero skips every entry
        drain();
        write_reg(twcm_pkg::REG_WINDOW, 20'd0);
        send_request(16'h2000, 48'd20000);
        drain();
        write_reg(twcm_pkg::REG_WINDOW, 20'hFFFFF);
        write_reg(twcm_pkg::REG_MIN_INTERVAL, 20'hFFFFF);
        send_request(16'h6000, 48'hFFFF_FFFF_FFFF);
        send_request(16'h1000, 48'h8000_0000_0000);
        send_request(16'h0001, 48'hFFFF_FFFF_FFFF);
        clock_us = 48'hFFFF_FFFF_FFFF - 48'd5000000;

        // Random phases across register settings; the second runs without idling
        // and then the sender holds off until all answers are in.
        random_phase(180, 48000, 900);
        idle_pct = 0;
        random_phase(120, 1000000, 0);
        drain();
        idle_pct = 37;
        random_phase(120, 1, 1000000);
        random_phase(120, 5000, 300);
        random_phase(90, $urandom_range(1, 1000000), $urandom_range(0, 20000));

        stim_done = 1'b1;
        drain();
        $display("Covered %0d fresh and %0d held answers over several register settings,",
                 board.fresh_count, board.held_count);
        $display("with random stalls on both sides and one no-idle stretch.");
        if (board.errors == 0) begin
            $display("PASS time_weighted_circular_mean");
        end else begin
            $display("FAIL time_weighted_circular_mean");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/twcm_pkg.sv
rtl/twcm_ram.sv
rtl/twcm_cordic.sv
rtl/time_weighted_circular_mean.sv
rtl/twcm_chk.sv
dv/time_weighted_circular_mean_tb.sv
